// File: rtl/mwc_pkg.sv
// ----------------------------------------------------------------------------
// mwc_pkg: shared types and tables for the markup whitespace compressor
// Beat structs for both channels, the internal op format between the front
// and back parts, character constants and the two marker strings.
// ----------------------------------------------------------------------------
package mwc_pkg;

	localparam int CHAR_W = 21;
	localparam int OFF_MARK_LEN = 15;
	localparam int ON_MARK_LEN = 14;
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(32'h20);
	localparam logic [CHAR_W-1:0] LT_CHAR = CHAR_W'(32'h3C);
	localparam logic [CHAR_W-1:0] GT_CHAR = CHAR_W'(32'h3E);

	// op kinds carried through the queue
	localparam logic [1:0] UOP_PLAIN = 2'd0;
	localparam logic [1:0] UOP_CLEAR = 2'd1;
	localparam logic [1:0] UOP_NOP = 2'd2;

	typedef struct packed {
		logic [CHAR_W-1:0] in_char;
		logic in_last;
	} in_beat_t;

	typedef struct packed {
		logic [CHAR_W-1:0] out_char;
		logic out_no_char;
		logic out_end;
	} out_beat_t;

	// one op for the back part: a character under a mode, a marker-done
	// clear, or nothing; last asks for end-of-text handling after it
	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic [1:0] kind;
		logic mode;
		logic last;
	} uop_t;

	// marker text; off_mark selects the string that ends compressing mode
	function automatic logic [7:0] mark_char(input logic off_mark, input logic [3:0] idx);
		logic [7:0] ch;
		case (idx)
			4'd0: ch = 8'h3C; // <
			4'd1: ch = 8'h21; // !
			4'd2: ch = 8'h2D; // -
			4'd3: ch = 8'h2D;
			4'd4: ch = 8'h20;
			4'd5: ch = 8'h53; // S
			4'd6: ch = 8'h43; // C
			4'd7: ch = 8'h5F; // _
			4'd8: ch = 8'h4F; // O
			4'd9: ch = off_mark ? 8'h46 : 8'h4E;
			4'd10: ch = off_mark ? 8'h46 : 8'h20;
			4'd11: ch = off_mark ? 8'h20 : 8'h2D;
			4'd12: ch = 8'h2D;
			4'd13: ch = off_mark ? 8'h2D : 8'h3E;
			4'd14: ch = off_mark ? 8'h3E : 8'h00;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_space(input logic [CHAR_W-1:0] c);
		return c inside {[21'h09:21'h0D], [21'h1C:21'h20], 21'h85, 21'hA0, 21'h1680,
			[21'h2000:21'h200A], 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000};
	endfunction

endpackage

// File: rtl/mwc_front.sv
// ----------------------------------------------------------------------------
// mwc_front: input side of the compressor
// Tracks marker matching and the compression mode, and turns each character
// into ops for the back part; held marker prefixes are replayed one op a cycle while the queue has room.
// ----------------------------------------------------------------------------
module mwc_front (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_stall,
	input mwc_pkg::in_beat_t text_beat,
	input logic q_full,
	output logic q_push,
	output mwc_pkg::uop_t q_wdata
);
	import mwc_pkg::*;

	logic mode_q;
	logic [3:0] prog_q;
	logic busy_q;
	logic [3:0] rep_idx_q;
	logic [3:0] rep_n_q;
	logic rep_mode_q;
	logic rep_last_q;
	uop_t tail_q;
	logic tail_vld_q;

	logic [CHAR_W-1:0] c;
	logic last;
	logic held;
	logic hit;
	logic start;
	logic accept;
	logic [3:0] lim;
	logic [3:0] prog_inc;
	logic [3:0] k;
	logic tv;
	logic [1:0] tk;
	logic [CHAR_W-1:0] tch;
	logic tmode;
	logic [3:0] nprog;
	logic nmode;
	uop_t tail;
	logic rep_more;
	logic rep_final;

	assign c = text_beat.in_char;
	assign last = text_beat.in_last;
	assign held = prog_q != 4'd0;
	assign lim = mode_q ? 4'(OFF_MARK_LEN) : 4'(ON_MARK_LEN);
	assign prog_inc = prog_q + 4'd1;
	assign hit = held && (c == {{(CHAR_W-8){1'b0}}, mark_char(mode_q, prog_q)});
	assign start = c == LT_CHAR;
	assign accept = text_valid && !text_stall;
	assign text_stall = busy_q || q_full;

	// classify the incoming character against the marker in progress
	always_comb begin
		k = 4'd0;
		tv = 1'b0;
		tk = UOP_NOP;
		tch = '0;
		tmode = mode_q;
		nprog = prog_q;
		nmode = mode_q;
		if (c == '0) begin
			if (last) begin
				if (held) k = prog_q;
				else tv = 1'b1;
			end
		end else if (hit) begin
			if (prog_inc == lim) begin
				tv = 1'b1;
				tk = UOP_CLEAR;
				nmode = !mode_q;
				tmode = !mode_q;
				nprog = 4'd0;
			end else begin
				nprog = prog_inc;
				if (last) k = prog_inc;
			end
		end else begin
			if (held) k = prog_q;
			if (start) begin
				nprog = 4'd1;
				if (last) begin
					tv = 1'b1;
					tk = UOP_PLAIN;
					tch = LT_CHAR;
				end
			end else begin
				nprog = 4'd0;
				tv = 1'b1;
				tk = UOP_PLAIN;
				tch = c;
			end
		end
		tail.ch = tch;
		tail.kind = tk;
		tail.mode = tmode;
		tail.last = last;
	end

	// queue write: replayed marker characters, the deferred tail, or a direct op
	assign rep_more = rep_idx_q != rep_n_q;
	assign rep_final = rep_idx_q == (rep_n_q - 4'd1);
	always_comb begin
		if (busy_q) begin
			if (rep_more) begin
				q_wdata.ch = {{(CHAR_W-8){1'b0}}, mark_char(rep_mode_q, rep_idx_q)};
				q_wdata.kind = UOP_PLAIN;
				q_wdata.mode = rep_mode_q;
				q_wdata.last = rep_last_q && rep_final;
				q_push = !q_full;
			end else begin
				q_wdata = tail_q;
				q_push = tail_vld_q && !q_full;
			end
		end else begin
			q_wdata = tail;
			q_push = accept && (k == 4'd0) && tv;
		end
	end

	// mode, match progress and replay sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
			prog_q <= 4'd0;
			busy_q <= 1'b0;
			rep_idx_q <= 4'd0;
			rep_n_q <= 4'd0;
			rep_mode_q <= 1'b1;
			rep_last_q <= 1'b0;
			tail_vld_q <= 1'b0;
		end else if (busy_q) begin
			if (!q_full) begin
				if (rep_more) begin
					rep_idx_q <= rep_idx_q + 4'd1;
					if (rep_final && !tail_vld_q) busy_q <= 1'b0;
				end else begin
					busy_q <= 1'b0;
				end
			end
		end else if (accept) begin
			mode_q <= last ? 1'b1 : nmode;
			prog_q <= last ? 4'd0 : nprog;
			if (k != 4'd0) begin
				busy_q <= 1'b1;
				rep_idx_q <= 4'd0;
				rep_n_q <= k;
				rep_mode_q <= mode_q;
				rep_last_q <= last && !tv;
				tail_vld_q <= tv;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!busy_q && accept) tail_q <= tail;
	end

	a_prog_below_lim: assert property (@(posedge clk) disable iff (!arst_n)
		prog_q < lim)
		else $error("marker progress reached marker length");
	a_busy_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rep_n_q != 4'd0))
		else $error("replay started with nothing held");
	a_replay_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rep_idx_q <= rep_n_q))
		else $error("replay index ran past held count");

endmodule

// File: rtl/mwc_queue.sv
// ----------------------------------------------------------------------------
// mwc_queue: op queue between front and back
// Small first-word-fall-through queue so the two sides stall independently.
// ----------------------------------------------------------------------------
module mwc_queue #(
	parameter int DEPTH = mwc_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	input mwc_pkg::uop_t wdata,
	output logic full,
	input logic pop,
	output logic nempty,
	output mwc_pkg::uop_t rdata
);
	import mwc_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	uop_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic do_push;
	logic do_pop;

	assign full = cnt_q == CNT_W'(DEPTH);
	assign nempty = cnt_q != '0;
	assign do_push = push && !full;
	assign do_pop = pop && nempty;
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |=> (cnt_q <= CNT_W'(1)))
		else $error("queue count jumped from empty");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with pointers apart");

endmodule

// File: rtl/mwc_back.sv
// ----------------------------------------------------------------------------
// mwc_back: output side of the compressor
// Applies the whitespace rules to each op, tracks the pending space and the
// after-'>' state, and produces up to two result beats per op.
// ----------------------------------------------------------------------------
module mwc_back (
	input logic clk,
	input logic arst_n,
	input logic q_nempty,
	input mwc_pkg::uop_t q_rdata,
	output logic q_pop,
	output logic comp_valid,
	input logic comp_stall,
	output mwc_pkg::out_beat_t comp_beat
);
	import mwc_pkg::*;

	logic sp_q;
	logic ac_q;
	out_beat_t out_q;
	logic out_vld_q;
	out_beat_t hold_q;
	logic hold_vld_q;

	logic take;
	logic sp_n;
	logic ac_n;
	logic em_lead;
	logic em_char;
	logic em_trail;
	logic em_none;
	logic [1:0] n_res;
	out_beat_t r0;
	out_beat_t r1;
	uop_t op;

	assign op = q_rdata;
	assign take = out_vld_q && !comp_stall;
	assign q_pop = q_nempty && !hold_vld_q && (!out_vld_q || take);
	assign comp_valid = out_vld_q;
	assign comp_beat = out_q;

	// whitespace rules for one op
	// a replayed prefix always gives a beat, so an end op that gives nothing
	// belongs to a character that gave nothing
	always_comb begin
		sp_n = sp_q;
		ac_n = ac_q;
		em_lead = 1'b0;
		em_char = 1'b0;
		if (op.kind == UOP_PLAIN) begin
			if (!op.mode) begin
				em_char = 1'b1;
			end else if (is_space(op.ch)) begin
				if (!ac_q) sp_n = 1'b1;
			end else begin
				em_lead = sp_q && (op.ch != LT_CHAR);
				em_char = 1'b1;
				sp_n = 1'b0;
				ac_n = op.ch == GT_CHAR;
			end
		end else if (op.kind == UOP_CLEAR) begin
			sp_n = 1'b0;
			ac_n = 1'b0;
		end
		em_trail = op.last && op.mode && sp_n;
		em_none = op.last && !em_lead && !em_char && !em_trail;
		n_res = 2'(em_lead) + 2'(em_char) + 2'(em_trail) + 2'(em_none);
	end

	// pack results in order; only a lead space and its character come in pairs
	always_comb begin
		r0.out_char = em_lead ? SPACE_CHAR : em_char ? op.ch : em_trail ? SPACE_CHAR : '0;
		r0.out_no_char = em_none;
		r0.out_end = op.last && (n_res == 2'd1);
		r1.out_char = op.ch;
		r1.out_no_char = 1'b0;
		r1.out_end = op.last;
	end

	// text state, cleared after each text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= 1'b0;
			ac_q <= 1'b0;
		end else if (q_pop) begin
			if (op.last) begin
				sp_q <= 1'b0;
				ac_q <= 1'b0;
			end else begin
				sp_q <= sp_n;
				ac_q <= ac_n;
			end
		end
	end

	// output register plus one hold stage for the second beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			hold_vld_q <= 1'b0;
		end else if (hold_vld_q) begin
			if (take || !out_vld_q) begin
				out_vld_q <= 1'b1;
				hold_vld_q <= 1'b0;
			end
		end else if (q_pop) begin
			if (n_res == 2'd0) out_vld_q <= out_vld_q && !take;
			else out_vld_q <= 1'b1;
			hold_vld_q <= n_res == 2'd2;
		end else if (take) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_vld_q) begin
			if (take || !out_vld_q) out_q <= hold_q;
		end else if (q_pop) begin
			if (n_res != 2'd0) out_q <= r0;
			if (n_res == 2'd2) hold_q <= r1;
		end
	end

	a_hold_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> out_vld_q)
		else $error("second beat held with output empty");
	a_no_char_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.out_no_char) |-> (out_q.out_end && (out_q.out_char == '0)))
		else $error("empty-text beat without end mark");
	a_pair_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && (n_res == 2'd2)) |-> (em_lead && em_char))
		else $error("unexpected pair of results");
	a_hold_not_end_first: assert property (@(posedge clk) disable iff (!arst_n)
		hold_vld_q |-> !out_q.out_end)
		else $error("end marked ahead of a held beat");

endmodule

// File: rtl/markup_whitespace_compressor_unit.sv
// ----------------------------------------------------------------------------
// markup_whitespace_compressor_unit: streaming markup whitespace compressor
// Input channel text_* takes one code point per beat with a last flag; the
// output channel comp_* gives the compressed characters of each text, the
// final beat of a text carrying out_end (or out_no_char when nothing was
// left). Runs of whitespace collapse to one space, whitespace before '<' or
// after '>' is dropped, NUL is dropped, and the SC_OFF / SC_ON comment
// markers are removed and switch compression off and on.
// Throughput: one character per cycle in steady state, while no replay runs
// and the output is not stalled. A character that breaks a partly matched
// marker, or a text ending inside one, stalls the input while the front part
// replays the held prefix (up to 14 characters) into the op queue, followed
// by the breaking character itself when it still has to go to the queue. A
// character that gives a space and itself leaves its second beat in the hold
// stage behind the output register. With an empty queue, an input beat passes
// the queue storage and then the back output register (front writes the queue, back registers the result).
// Reset (arst_n low) empties queue and output, and sets compressing mode.
// A stall on comp_stall holds the output beat; the queue then fills and
// text_stall rises, with no beat lost.
// ----------------------------------------------------------------------------
module markup_whitespace_compressor_unit #(
	parameter int QUEUE_DEPTH = mwc_pkg::QUEUE_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic text_valid,
	output logic text_stall,
	input mwc_pkg::in_beat_t text_beat,
	output logic comp_valid,
	input logic comp_stall,
	output mwc_pkg::out_beat_t comp_beat
);
	import mwc_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_nempty;
	uop_t q_wdata;
	uop_t q_rdata;

	// character classification and marker matching
	mwc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_beat(text_beat),
		.q_full(q_full),
		.q_push(q_push),
		.q_wdata(q_wdata)
	);

	// decoupling queue
	mwc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.wdata(q_wdata),
		.full(q_full),
		.pop(q_pop),
		.nempty(q_nempty),
		.rdata(q_rdata)
	);

	// whitespace rules and output beats
	mwc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_nempty(q_nempty),
		.q_rdata(q_rdata),
		.q_pop(q_pop),
		.comp_valid(comp_valid),
		.comp_stall(comp_stall),
		.comp_beat(comp_beat)
	);

endmodule

// File: sim/markup_whitespace_compressor_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// markup_whitespace_compressor_unit_test: stream test of the whitespace compressor
// Feeds texts one code point per beat: a short hand-picked set first, then
// random texts built mostly from SC_OFF / SC_ON markers, broken marker
// prefixes, whitespace, tag brackets and odd code points. A scoreboard
// class predicts the compressed output of every accepted beat and checks
// each output beat in order, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module markup_whitespace_compressor_unit_test;
	import mwc_pkg::*;

	// compressor prediction and in-order output check
	class text_compressor_model;
		out_beat_t compressed_q[$];
		int unsigned mismatches;
		bit squeeze_on;
		bit gap_pending;
		bit after_gt;
		int unsigned held_len;
		int unsigned beats_this_char;
		string off_marker;
		string on_marker;

		function new();
			off_marker = "<!-- SC_OFF -->";
			on_marker = "<!-- SC_ON -->";
			mismatches = 0;
			clear_state();
		endfunction

		function void clear_state();
			squeeze_on = 1'b1;
			gap_pending = 1'b0;
			after_gt = 1'b0;
			held_len = 0;
		endfunction

		function bit is_blank(logic [CHAR_W-1:0] c);
			if (c >= 21'h09 && c <= 21'h0D) return 1'b1;
			if (c >= 21'h1C && c <= 21'h20) return 1'b1;
			if (c == 21'h85 || c == 21'hA0 || c == 21'h1680) return 1'b1;
			if (c >= 21'h2000 && c <= 21'h200A) return 1'b1;
			if (c == 21'h2028 || c == 21'h2029 || c == 21'h202F) return 1'b1;
			return (c == 21'h205F || c == 21'h3000);
		endfunction

		// marker of the current mode, the one that would flip it
		function logic [CHAR_W-1:0] marker_at(int unsigned idx);
			string m;
			m = squeeze_on ? off_marker : on_marker;
			return {13'd0, m[idx]};
		endfunction

		function void push_char(logic [CHAR_W-1:0] c);
			out_beat_t b;
			if (beats_this_char >= 17) return;
			b.out_char = c;
			b.out_no_char = 1'b0;
			b.out_end = 1'b0;
			compressed_q.push_back(b);
			beats_this_char++;
		endfunction

		// one character under the current mode, no marker detection
		function void plain_char(logic [CHAR_W-1:0] c);
			if (!squeeze_on) begin
				push_char(c);
				return;
			end
			if (is_blank(c)) begin
				if (!after_gt) gap_pending = 1'b1;
				return;
			end
			if (gap_pending && c != LT_CHAR) push_char(SPACE_CHAR);
			gap_pending = 1'b0;
			after_gt = 1'b0;
			push_char(c);
			if (c == GT_CHAR) after_gt = 1'b1;
		endfunction

		function void replay_held();
			int unsigned n;
			n = held_len;
			held_len = 0;
			for (int unsigned i = 0; i < n; i++) plain_char(marker_at(i));
		endfunction

		function void handle_char(logic [CHAR_W-1:0] c);
			int unsigned lim;
			lim = squeeze_on ? OFF_MARK_LEN : ON_MARK_LEN;
			if (held_len > 0) begin
				if (c == marker_at(held_len)) begin
					held_len++;
					// full marker: drop it and flip the mode
					if (held_len >= lim) begin
						squeeze_on = !squeeze_on;
						held_len = 0;
						gap_pending = 1'b0;
						after_gt = 1'b0;
					end
					return;
				end
				replay_held();
			end
			if (c == marker_at(0)) begin
				held_len = 1;
				return;
			end
			plain_char(c);
		endfunction

		// accepted input beat: append its expected output beats
		function void take_char(in_beat_t b);
			out_beat_t tail;
			beats_this_char = 0;
			if (b.in_char != '0) handle_char(b.in_char);
			if (b.in_last) begin
				if (held_len > 0) replay_held();
				if (squeeze_on && gap_pending) push_char(SPACE_CHAR);
				if (beats_this_char == 0) begin
					tail.out_char = '0;
					tail.out_no_char = 1'b1;
					tail.out_end = 1'b1;
				end else begin
					tail = compressed_q.pop_back();
					tail.out_end = 1'b1;
				end
				compressed_q.push_back(tail);
				clear_state();
			end
		endfunction

		// accepted output beat against the oldest expected one
		function void match_out(out_beat_t got);
			out_beat_t want;
			if (compressed_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output beat: char=%h no_char=%b end=%b",
						got.out_char, got.out_no_char, got.out_end);
				return;
			end
			want = compressed_q.pop_front();
			if (got.out_char !== want.out_char || got.out_no_char !== want.out_no_char ||
					got.out_end !== want.out_end) begin
				mismatches++;
				if (mismatches <= 10)
					$display("output mismatch: expected char=%h no_char=%b end=%b, got char=%h no_char=%b end=%b",
						want.out_char, want.out_no_char, want.out_end,
						got.out_char, got.out_no_char, got.out_end);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic text_stall;
	in_beat_t text_beat = '0;
	logic comp_valid;
	logic comp_stall = 1'b0;
	out_beat_t comp_beat;

	text_compressor_model compressor;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int chars_sent;
	logic [CHAR_W-1:0] text_q[$];
	string off_text = "<!-- SC_OFF -->";
	string on_text = "<!-- SC_ON -->";

	markup_whitespace_compressor_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_beat(text_beat),
		.comp_valid(comp_valid),
		.comp_stall(comp_stall),
		.comp_beat(comp_beat)
	);

	always #5 clk = ~clk;

	// beat monitors and receiver stall
	always @(posedge clk) begin
		if (arst_n) begin
			if (comp_valid && !comp_stall) compressor.match_out(comp_beat);
			if (text_valid && !text_stall) compressor.take_char(text_beat);
		end
		comp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// one input beat, with random idle cycles ahead of it
	task automatic send_beat(input logic [CHAR_W-1:0] ch, input logic last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			text_valid <= 1'b0;
			@(posedge clk);
		end
		text_valid <= 1'b1;
		text_beat <= '{in_char: ch, in_last: last};
		do @(posedge clk); while (text_stall);
		if (ch != '0) chars_sent++;
	endtask

	task automatic send_queued_text();
		for (int i = 0; i < text_q.size(); i++) send_beat(text_q[i], i == text_q.size() - 1);
		text_q.delete();
	endtask

	// hold the sender until every expected beat is out
	task automatic drain_output();
		text_valid <= 1'b0;
		do @(posedge clk); while (compressor.compressed_q.size() != 0);
	endtask

	function automatic void push_marker(input bit off, input int len);
		for (int i = 0; i < len; i++) begin
			text_q.push_back({13'd0, off ? off_text[i] : on_text[i]});
			// a stray nul inside a marker must not break it
			if ($urandom_range(0, 15) == 0) text_q.push_back('0);
		end
	endfunction

	function automatic logic [CHAR_W-1:0] pick_blank();
		case ($urandom_range(0, 7))
			0: return 21'($urandom_range(32'h09, 32'h0D));
			1: return 21'($urandom_range(32'h1C, 32'h20));
			2: return 21'h85;
			3: return 21'hA0;
			4: return 21'h1680;
			5: return 21'($urandom_range(32'h2000, 32'h200A));
			6: return $urandom_range(0, 2) == 0 ? 21'h2028 :
				($urandom_range(0, 1) ? 21'h2029 : 21'h202F);
			default: return $urandom_range(0, 1) ? 21'h205F : 21'h3000;
		endcase
	endfunction

	// code points just outside the whitespace set
	function automatic logic [CHAR_W-1:0] pick_near_blank();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1) ? 21'h08 : 21'h0E;
			1: return $urandom_range(0, 1) ? 21'h1B : 21'h21;
			2: return $urandom_range(0, 1) ? 21'h84 : 21'h86;
			3: return $urandom_range(0, 1) ? 21'h9F : 21'hA1;
			4: return $urandom_range(0, 1) ? 21'h167F : 21'h1681;
			5: return $urandom_range(0, 1) ? 21'h1FFF : 21'h200B;
			6: return $urandom_range(0, 1) ? 21'h2027 : 21'h202A;
			7: return $urandom_range(0, 1) ? 21'h202E : 21'h2030;
			8: return $urandom_range(0, 1) ? 21'h205E : 21'h2060;
			default: return $urandom_range(0, 1) ? 21'h2FFF : 21'h3001;
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char();
		case ($urandom_range(0, 9))
			0, 1: return 21'($urandom_range(32'h61, 32'h7A));
			2: return pick_blank();
			3: return SPACE_CHAR;
			4: return LT_CHAR;
			5: return GT_CHAR;
			6: return '0;
			7: return 21'($urandom_range(0, 32'h1FFFFF));
			8: begin
				case ($urandom_range(0, 7))
					0: return 21'h21;
					1: return 21'h2D;
					2: return 21'h53;
					3: return 21'h43;
					4: return 21'h5F;
					5: return 21'h4F;
					6: return 21'h46;
					default: return 21'h4E;
				endcase
			end
			default: return pick_near_blank();
		endcase
	endfunction

	// random text: markers, broken prefixes and runs of characters
	task automatic send_random_text();
		int n_segs;
		int len;
		bit off;
		n_segs = $urandom_range(1, 8);
		for (int s = 0; s < n_segs; s++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3: push_marker(1'b1, OFF_MARK_LEN);
				4, 5, 6: push_marker(1'b0, ON_MARK_LEN);
				7, 8, 9: begin
					off = $urandom_range(0, 1);
					len = $urandom_range(1, (off ? OFF_MARK_LEN : ON_MARK_LEN) - 1);
					push_marker(off, len);
					if ($urandom_range(0, 1)) text_q.push_back(pick_char());
				end
				default: begin
					len = $urandom_range(1, 6);
					for (int i = 0; i < len; i++) text_q.push_back(pick_char());
				end
			endcase
		end
		send_queued_text();
	endtask

	// run limit
	initial begin
		#4000000;
		$display("markup_whitespace_compressor_unit verification failed");
		$finish;
	end

	initial begin
		compressor = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: top code point, blanks, nul, '>' then blank, broken prefix
		send_beat(21'h1FFFFF, 1'b0);
		send_beat(21'h3000, 1'b0);
		send_beat('0, 1'b0);
		send_beat(GT_CHAR, 1'b0);
		send_beat(21'h09, 1'b0);
		send_beat(LT_CHAR, 1'b0);
		send_beat(21'h70, 1'b0);
		send_beat(21'h2029, 1'b1);
		// empty text: nul carrying last
		send_beat('0, 1'b1);
		// off marker, then blanks copied verbatim up to the end
		push_marker(1'b1, OFF_MARK_LEN);
		text_q.push_back(SPACE_CHAR);
		text_q.push_back(21'h0A);
		send_queued_text();
		drain_output();

		// random texts over the idle and stall phases
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 46; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 46; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			chars_sent = 0;
			while (chars_sent < 108) send_random_text();
			drain_output();
		end

		// settle: no stall, watch for stray beats
		recv_stall_pct = 0;
		while (compressor.compressed_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (compressor.mismatches == 0 && compressor.compressed_q.size() == 0)
			$display("markup_whitespace_compressor_unit verification clean");
		else
			$display("markup_whitespace_compressor_unit verification failed");
		$finish;
	end

endmodule
